/* rtl/gbk_pkg.sv */
// Shared types and constants for the group-by key assigner.
// No dependencies; imported by gbk_cell, group_by_key_assigner_top and the bench tb.
`timescale 1ns / 1ps

package gbk_pkg;

    localparam int MAX_GROUPS = 64;
    localparam int MAX_ROWS   = 65536;

    localparam int KEY_W    = 64;
    localparam int ROW_W    = 16;
    localparam int GROUP_W  = 6;
    localparam int SLOT_W   = 16;
    localparam int STATUS_W = 2;

    localparam int GIDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);

    localparam logic [SLOT_W-1:0] COUNT_TOP = {SLOT_W{1'b1}};

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ROW_LIMIT = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic              limit;
        logic              found;
        logic              opened;
        logic [GIDX_W-1:0] group;
        logic [SLOT_W-1:0] slot;
    } row_pkt_t;

endpackage

/* rtl/gbk_cell.sv */
// One group cell: holds a key and its member count, matches or claims the passing row.
// Depends on gbk_pkg.
`timescale 1ns / 1ps

module gbk_cell
    import gbk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [GIDX_W-1:0] cell_index,
    input  logic              load,
    input  logic              in_valid,
    input  row_pkt_t          in_pkt,
    output logic              out_valid,
    output row_pkt_t          out_pkt
);

    logic              valid_reg;
    logic              in_use_reg;
    logic              in_use_next;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [SLOT_W-1:0] count_reg;
    logic [SLOT_W-1:0] count_next;
    row_pkt_t          pkt_reg;
    row_pkt_t          pkt_next;
    logic              match;
    logic              claim;
    logic              busy;

    assign busy  = in_pkt.found | in_pkt.limit;
    assign match = in_use_reg & (key_reg == in_pkt.key) & ~busy;
    assign claim = ~in_use_reg & ~busy;

    always_comb
    begin
        pkt_next    = in_pkt;
        in_use_next = in_use_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        if (match)
        begin
            pkt_next.found = 1'b1;
            pkt_next.group = cell_index;
            pkt_next.slot  = count_reg;
            if (count_reg != COUNT_TOP)
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else if (claim)
        begin
            pkt_next.found  = 1'b1;
            pkt_next.opened = 1'b1;
            pkt_next.group  = cell_index;
            pkt_next.slot   = '0;
            in_use_next     = 1'b1;
            key_next        = in_pkt.key;
            count_next      = {{(SLOT_W-1){1'b0}}, 1'b1};
        end
        // frame end: table clears behind the last row
        if (in_pkt.last)
        begin
            in_use_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            in_use_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
            if (in_valid)
            begin
                in_use_reg <= in_use_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pkt_reg <= pkt_next;
            if (in_valid)
            begin
                key_reg   <= key_next;
                count_reg <= count_next;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_pkt   = pkt_reg;

endmodule

/* rtl/group_by_key_assigner_top.sv */
// Top level of the group-by key assigner: row counter, cell chain, result packing.
// Depends on gbk_pkg and gbk_cell.
`timescale 1ns / 1ps

// Usage:
//   Input stream (s_axis_*): one row per transfer, tdata = key, tlast marks the
//   final row of a frame. Output stream (m_axis_*): one result per row, in order.
//   Each row walks a chain of MAX_GROUPS cells, one cell per cycle while not stalled;
//   a cell whose key matches takes the row into its group, the first free cell opens
//   a new group. m_axis_tvalid rises once the row has passed the register of every cell.
//   Throughput is one row per cycle while m_axis_tready does not stall the chain;
//   every cell stage is a register, so rows follow each other through the chain.
//   Stalls: each stage holds while the one after it is full and blocked, so
//   m_axis_tready low fills the chain's empty stages before s_axis_tready drops.
//   Reset clears the row counter, the in-use flag of every cell and all stage
//   valids; stored keys and counts need no reset.
//   After the row with tlast the row counter clears at once and each cell frees
//   itself as that row passes, so the next frame may follow directly.
//   Rows beyond MAX_ROWS in a frame report status row-limit and join no group.

module group_by_key_assigner_top
    import gbk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [KEY_W-1:0]    s_axis_tdata,   // [63:0] key
    input  logic                s_axis_tlast,   // last_row
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // [15:0] row_number, [21:16] group_index,
                                                // [22] opened_group, [38:23] slot_in_group
    output logic [STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

    logic [ROWS_W-1:0] rows_seen_reg;
    logic [ROWS_W-1:0] rows_seen_next;
    logic              limit;
    logic              in_xfer;
    row_pkt_t          entry_pkt;

    row_pkt_t          pkt   [MAX_GROUPS+1];
    logic              vld   [MAX_GROUPS+1];
    logic              ready [MAX_GROUPS+1];

    row_pkt_t          res;

    assign limit   = (rows_seen_reg >= ROWS_W'(MAX_ROWS));
    assign in_xfer = s_axis_tvalid & s_axis_tready;

    always_comb
    begin
        entry_pkt        = '0;
        entry_pkt.key    = s_axis_tdata;
        entry_pkt.last   = s_axis_tlast;
        entry_pkt.limit  = limit;
        entry_pkt.row    = limit ? '0 : ROW_W'(rows_seen_reg);
        rows_seen_next   = rows_seen_reg;
        if (s_axis_tlast)
        begin
            rows_seen_next = '0;
        end
        else if (!limit)
        begin
            rows_seen_next = rows_seen_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_seen_reg <= '0;
        end
        else if (in_xfer)
        begin
            rows_seen_reg <= rows_seen_next;
        end
    end

    assign pkt[0]            = entry_pkt;
    assign vld[0]            = s_axis_tvalid;
    assign ready[MAX_GROUPS] = m_axis_tready;
    assign s_axis_tready     = ready[0];

    genvar i;
    generate
        for (i = 0; i < MAX_GROUPS; i++)
        begin : g_cell
            assign ready[i] = ~vld[i+1] | ready[i+1];

            gbk_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (GIDX_W'(i)),
                .load       (ready[i]),
                .in_valid   (vld[i]),
                .in_pkt     (pkt[i]),
                .out_valid  (vld[i+1]),
                .out_pkt    (pkt[i+1])
            );
        end
    endgenerate

    assign res           = pkt[MAX_GROUPS];
    assign m_axis_tvalid = vld[MAX_GROUPS];

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tuser = ST_OK;
        if (res.limit)
        begin
            m_axis_tuser = ST_ROW_LIMIT;
        end
        else if (!res.found)
        begin
            m_axis_tuser        = ST_TABLE_FULL;
            m_axis_tdata[15:0]  = res.row;
        end
        else
        begin
            m_axis_tdata[15:0]  = res.row;
            m_axis_tdata[21:16] = GROUP_W'(res.group);
            m_axis_tdata[22]    = res.opened;
            m_axis_tdata[38:23] = res.slot;
        end
    end

endmodule

/* tb/sv/tb.sv */
// Self-checking bench for group_by_key_assigner_top: streams key rows, predicts group
// assignment per row in a local table, and checks every result transfer in order.
// Depends on gbk_pkg and the RTL of group_by_key_assigner_top.
`timescale 1ns / 1ps

module tb
    import gbk_pkg::*;
();

    localparam int SETTLE_CYCLES = 2 * MAX_GROUPS + 16;
    localparam int RANDOM_ROWS   = 1000;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic             last;
        logic             hold;     // wait for all results before sending
    } row_item_t;

    typedef struct {
        logic [ROW_W-1:0]    row;
        logic [GROUP_W-1:0]  group;
        logic                opened;
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
    } group_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [KEY_W-1:0]    s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [39:0]         m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    row_item_t     pending_rows[$];
    group_result_t expected_results[$];

    // predicted group table
    logic [KEY_W-1:0]  table_keys[MAX_GROUPS];
    logic [SLOT_W-1:0] table_counts[MAX_GROUPS];
    int unsigned       groups_used = 0;
    int unsigned       frame_rows = 0;

    int mismatches = 0;
    bit idle_on = 1'b1;
    int send_gap = 0;
    int stall_left = 0;
    int heavy_left = 0;

    group_by_key_assigner_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    task automatic assign_group(input logic [KEY_W-1:0] key, input logic last);
        group_result_t res;
        int            g;
        bit            hit;
        res.row    = '0;
        res.group  = '0;
        res.opened = 1'b0;
        res.slot   = '0;
        res.status = ST_OK;
        hit = 1'b0;
        g = 0;
        if (frame_rows >= MAX_ROWS)
        begin
            res.status = ST_ROW_LIMIT;
        end
        else
        begin
            res.row = frame_rows[ROW_W-1:0];
            frame_rows++;
            for (int i = 0; i < groups_used; i++)
            begin
                if (!hit && table_keys[i] == key)
                begin
                    hit = 1'b1;
                    g = i;
                end
            end
            if (!hit)
            begin
                if (groups_used >= MAX_GROUPS)
                begin
                    res.status = ST_TABLE_FULL;
                end
                else
                begin
                    g = groups_used;
                    groups_used++;
                    table_keys[g] = key;
                    table_counts[g] = '0;
                    res.opened = 1'b1;
                    hit = 1'b1;
                end
            end
            if (hit)
            begin
                res.group = g[GROUP_W-1:0];
                res.slot = table_counts[g];
                if (table_counts[g] != COUNT_TOP)
                    table_counts[g]++;
            end
        end
        expected_results.push_back(res);
        if (last)
        begin
            groups_used = 0;
            frame_rows = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        mismatches++;
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        row_item_t nxt;
        bit        take;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            take = !s_axis_tvalid || s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                assign_group(s_axis_tdata, s_axis_tlast);
            if (take)
            begin
                if (idle_on && send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 5) == 0)
                begin
                    send_gap = $urandom_range(0, 9);
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_rows.size() != 0 &&
                         (!pending_rows[0].hold || expected_results.size() == 0))
                begin
                    nxt = pending_rows.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.key;
                    s_axis_tlast  <= nxt.last;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : monitor
        group_result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result, row_number", 0, m_axis_tdata[15:0]);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[15:0] !== want.row)
                        report_mismatch("row_number", want.row, m_axis_tdata[15:0]);
                    if (m_axis_tdata[21:16] !== want.group)
                        report_mismatch("group_index", want.group, m_axis_tdata[21:16]);
                    if (m_axis_tdata[22] !== want.opened)
                        report_mismatch("opened_group", want.opened, m_axis_tdata[22]);
                    if (m_axis_tdata[38:23] !== want.slot)
                        report_mismatch("slot_in_group", want.slot, m_axis_tdata[38:23]);
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", want.status, m_axis_tuser);
                end
            end
            // long heavy-stall stretches back up the cell chain to the input
            if (heavy_left > 0)
                heavy_left--;
            else if ($urandom_range(0, 299) == 0)
                heavy_left = $urandom_range(100, 400);
            if (idle_on && stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) < ((heavy_left > 0) ? 7 : 1))
            begin
                stall_left = $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    task automatic push_row(input logic [KEY_W-1:0] key, input logic last,
                            input logic hold);
        row_item_t it;
        it.key = key;
        it.last = last;
        it.hold = hold;
        pending_rows.push_back(it);
    endtask

    task automatic wait_quiet();
        while (pending_rows.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [KEY_W-1:0] pool[8];
        logic [KEY_W-1:0] seen[$];
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] k;
        int               total;
        int               len;
        int               npool;
        int               kind;
        bit               first;
        bit               hold;

        // directed: key extremes, hits, single-row frame, keys differing only in the sign bit
        push_row(64'h0000_0000_0000_0000, 1'b0, 1'b0);
        push_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        push_row(64'h8000_0000_0000_0000, 1'b0, 1'b0);
        push_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        push_row(64'h0000_0000_0000_0000, 1'b0, 1'b0);
        push_row(64'h5555_5555_5555_5555, 1'b0, 1'b0);
        push_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
        push_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        push_row(64'h8000_0000_0000_0000, 1'b1, 1'b0);
        push_row(64'h0000_0000_0000_0000, 1'b1, 1'b0);
        push_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        push_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
        push_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
        push_row(64'h0000_0000_0000_0001, 1'b0, 1'b0);
        push_row(64'h8000_0000_0000_0001, 1'b0, 1'b0);
        push_row(64'h0000_0000_0000_0001, 1'b0, 1'b0);
        push_row(64'h8000_0000_0000_0001, 1'b1, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait_quiet();

        // random frames
        total = 0;
        first = 1'b1;
        while (total < RANDOM_ROWS)
        begin
            kind = $urandom_range(0, 9);
            hold = first || ($urandom_range(0, 15) == 0);
            first = 1'b0;
            if (kind < 7)
            begin
                // short frame over a small key pool
                len = $urandom_range(1, 40);
                npool = $urandom_range(1, 8);
                for (int i = 0; i < npool; i++)
                begin
                    case ($urandom_range(0, 7))
                        0: pool[i] = 64'h8000_0000_0000_0000;
                        1: pool[i] = 64'h7FFF_FFFF_FFFF_FFFF;
                        2: pool[i] = 64'hFFFF_FFFF_FFFF_FFFF;
                        3: pool[i] = 64'h0;
                        default: pool[i] = rand_key();
                    endcase
                end
                for (int r = 0; r < len; r++)
                begin
                    k = ($urandom_range(0, 19) == 0) ? rand_key()
                                                     : pool[$urandom_range(0, npool - 1)];
                    push_row(k, r == len - 1, (r == 0) && hold);
                end
            end
            else if (kind < 9)
            begin
                // wide frame: more rows than the group table has groups, mixes in hits
                len = $urandom_range(MAX_GROUPS + 2, MAX_GROUPS + 56);
                seen.delete();
                for (int r = 0; r < len; r++)
                begin
                    if (seen.size() != 0 && $urandom_range(0, 3) == 0)
                        k = seen[$urandom_range(0, seen.size() - 1)];
                    else
                    begin
                        k = rand_key();
                        seen.push_back(k);
                    end
                    push_row(k, r == len - 1, (r == 0) && hold);
                end
            end
            else
            begin
                // noise: random keys, random frame ends
                len = $urandom_range(1, 20);
                for (int r = 0; r < len; r++)
                    push_row(rand_key(), $urandom_range(0, 2) == 0, (r == 0) && hold);
            end
            total += len;
        end
        wait_quiet();

        // full-rate tail: table filled and overrun with hits mixed in, then a short frame
        idle_on = 1'b0;
        base = rand_key();
        for (int r = 0; r < MAX_GROUPS + 8; r++)
        begin
            if (r < MAX_GROUPS)
                k = base + r;
            else if (r == MAX_GROUPS)
                k = base + MAX_GROUPS;
            else if (r == MAX_GROUPS + 1)
                k = base - 1;
            else
                k = base + (r % MAX_GROUPS);
            push_row(k, r == MAX_GROUPS + 7, 1'b0);
        end
        push_row(base, 1'b0, 1'b0);
        push_row(base + 1, 1'b0, 1'b0);
        push_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
